[hdl/dtp_pkg.sv]
`default_nettype none

package dtp_pkg;

    // Default buffer depth in characters.
    localparam int unsigned MAX_TEXT_CHARS_DEF = 64;

    // Character codes used by the parser.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Field limits and zone coding.
    localparam logic [7:0]  MONTH_MAX  = 8'd12;
    localparam logic [7:0]  DAY_MAX    = 8'd31;
    localparam logic [7:0]  HOUR_MAX   = 8'd23;
    localparam logic [7:0]  MINSEC_MAX = 8'd59;
    localparam logic [7:0]  ZONE_BASE  = 8'd100;
    localparam logic [7:0]  ZONE_MIRROR = 8'd200;
    localparam logic [4:0]  QUARTER    = 5'd15;
    // Inverse of fifteen modulo 256: an exact multiple of fifteen times this
    // gives the low byte of the quotient.
    localparam logic [7:0]  QUARTER_INV = 8'd239;
    localparam logic signed [15:0] CENTURY_SPLIT = 16'sd30;
    localparam logic signed [15:0] CENTURY_TOP   = 16'sd100;
    localparam logic signed [15:0] ADD_1900      = 16'sd1900;
    localparam logic signed [15:0] ADD_2000      = 16'sd2000;

    typedef enum logic [5:0] {
        S_IDLE, S_PRIME, S_DSP, S_YDONE, S_YSKIP, S_MODONE, S_MOSKIP,
        S_DDONE, S_DSKIP, S_TSP, S_HDONE, S_HSKIP, S_MIDONE, S_MISKIP,
        S_SDONE, S_SSKIP, S_ZSP, S_ZSHORT, S_ZC3, S_ZC4, S_ZAM, S_ZAD,
        S_ZBCHK, S_ZBM, S_ZBD, S_ZCCHK, S_ZCM, S_ZCD, S_ZHOUR,
        S_RNWS, S_RNDIG, S_OK, S_FAIL
    } state_t;

endpackage

`default_nettype wire

[hdl/dtp_ram.sv]
`default_nettype none

module dtp_ram
    import dtp_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = MAX_TEXT_CHARS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/date_time_text_parser_top.sv]
`default_nettype none

// Date and time text parser.
//
// Input channel: a character transfer happens at a rising edge where start is
// high and busy is low. A non-zero ch is stored in the text buffer; a zero ch
// or a character with last set ends the text (a zero byte is not stored).
// While characters are loading the block takes one transfer every cycle.
//
// Once a text ends, busy rises and a sequencer parses the buffer with one
// character read per cycle from the buffer RAM, one shared multiply-by-ten
// accumulator for the numbers, and a small modulo-fifteen unit that splits the
// zone minutes into quarter hours. The zone may reread its short tail up to
// four more times, so the rate is set by the single RAM read port and the
// shared accumulator. When it finishes, done is high for exactly one cycle
// together with valid_res and the fields, and busy falls in that same
// cycle.
//
// The receiver cannot stall: the result is shown once and must be taken.
// Reset clears the text length, the overflow flag and the sequencer; the
// buffer contents need no clearing because only written entries are read.

module date_time_text_parser_top
    import dtp_pkg::*;
#(
    parameter int unsigned MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         ch,
    input  wire logic               last,
    output logic                    done,
    output logic                    valid_res,
    output logic signed [15:0]      year,
    output logic [7:0]              month,
    output logic [7:0]              day,
    output logic [7:0]              hour,
    output logic [7:0]              minute,
    output logic [7:0]              second,
    output logic [7:0]              zone_code
);

    localparam int unsigned AW = $clog2(MAX_TEXT_CHARS);
    localparam int unsigned LW = $clog2(MAX_TEXT_CHARS + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TEXT_CHARS);

    // Low byte of the value an atoi-style read returns.
    function automatic logic [7:0] low8(input logic n, input logic [31:0] m);
        logic [7:0] r;
        if (n)
        begin
            r = 8'd0 - m[7:0];
        end
        else if (m[31])
        begin
            r = 8'hFF;
        end
        else
        begin
            r = m[7:0];
        end
        return r;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // Remainder modulo fifteen: sixteen is one more than fifteen, so the
    // nibbles are summed and the sum folded until it fits in one nibble.
    function automatic logic [3:0] mod15(input logic [31:0] v);
        logic [6:0] s;
        logic [4:0] f1;
        logic [3:0] f2;
        s  = {3'd0, v[3:0]}   + {3'd0, v[7:4]}   + {3'd0, v[11:8]}  +
             {3'd0, v[15:12]} + {3'd0, v[19:16]} + {3'd0, v[23:20]} +
             {3'd0, v[27:24]} + {3'd0, v[31:28]};
        f1 = {2'd0, s[6:4]} + {1'b0, s[3:0]};
        f2 = {3'd0, f1[4]} + f1[3:0];
        return ({1'b0, f2} == QUARTER) ? 4'd0 : f2;
    endfunction

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] ldash_reg, ldash_next;
    logic [LW-1:0] lslash_reg, lslash_next;
    logic [LW-1:0] lcolon_reg, lcolon_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] end_reg, end_next;
    logic [LW-1:0] zp_reg, zp_next;
    logic [31:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic          minus_reg, minus_next;
    logic          got_reg, got_next;
    logic [7:0]    c3_reg, c3_next;
    logic [7:0]    c4_reg, c4_next;
    logic [7:0]    q_reg, q_next;
    logic [3:0]    drem_reg, drem_next;

    logic signed [15:0] fyear_reg, fyear_next;
    logic [7:0] fmon_reg, fmon_next, fday_reg, fday_next;
    logic [7:0] fhour_reg, fhour_next, fmin_reg, fmin_next;
    logic [7:0] fsec_reg, fsec_next, fzone_reg, fzone_next;

    logic               done_reg, done_next;
    logic               oval_reg, oval_next;
    logic signed [15:0] oyear_reg, oyear_next;
    logic [7:0] omon_reg, omon_next, oday_reg, oday_next;
    logic [7:0] ohour_reg, ohour_next, omin_reg, omin_next;
    logic [7:0] osec_reg, osec_next, ozone_reg, ozone_next;

    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic [7:0]    c;
    logic          accept;
    logic          store;
    logic [34:0]   acc;
    logic [3:0]    zrem;
    logic [7:0]    zqa;
    logic [7:0]    nlow;
    logic [LW-1:0] remain;
    logic [31:0]   absval;
    logic signed [15:0] ysat;

    assign accept = start && !busy;
    assign store  = accept && (ch != 8'd0) && (len_reg < LEN_MAX);
    assign ram_we = store;

    dtp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT_CHARS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (ch),
        .raddr (ptr_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    // The read address follows the next pointer, so the data seen in a cycle
    // always belongs to the current pointer.
    assign c = (ptr_reg < len_reg) ? ram_rdata : 8'd0;

    // Shared accumulator and the quarter-hour split of the zone minutes.
    assign acc    = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                    + {31'd0, c[3:0]};
    assign nlow   = low8(neg_reg, mag_reg);
    assign remain = len_reg - ptr_reg;
    assign absval = (!neg_reg && mag_reg[31]) ? 32'h7FFF_FFFF : mag_reg;
    assign zrem   = mod15(absval);
    assign zqa    = (absval[7:0] - {4'd0, zrem}) * QUARTER_INV;

    always_comb
    begin
        if (neg_reg)
        begin
            ysat = (mag_reg > 32'd32768) ? 16'sh8000 : 16'(16'd0 - mag_reg[15:0]);
        end
        else
        begin
            ysat = (mag_reg > 32'd32767) ? 16'sh7FFF : signed'(mag_reg[15:0]);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        ldash_next  = ldash_reg;
        lslash_next = lslash_reg;
        lcolon_next = lcolon_reg;
        ptr_next    = ptr_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        zp_next     = zp_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        minus_next  = minus_reg;
        got_next    = got_reg;
        c3_next     = c3_reg;
        c4_next     = c4_reg;
        q_next      = q_reg;
        drem_next   = drem_reg;
        fyear_next  = fyear_reg;
        fmon_next   = fmon_reg;
        fday_next   = fday_reg;
        fhour_next  = fhour_reg;
        fmin_next   = fmin_reg;
        fsec_next   = fsec_reg;
        fzone_next  = fzone_reg;
        done_next   = 1'b0;
        oval_next   = oval_reg;
        oyear_next  = oyear_reg;
        omon_next   = omon_reg;
        oday_next   = oday_reg;
        ohour_next  = ohour_reg;
        omin_next   = omin_reg;
        osec_next   = osec_reg;
        ozone_next  = ozone_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                if (accept)
                begin
                    if (ch != 8'd0)
                    begin
                        if (len_reg < LEN_MAX)
                        begin
                            len_next = len_reg + 1'b1;
                            if (ch == CH_MINUS)
                            begin
                                ldash_next = len_reg + 1'b1;
                            end
                            if (ch == CH_SLASH)
                            begin
                                lslash_next = len_reg + 1'b1;
                            end
                            if (ch == CH_COLON)
                            begin
                                lcolon_next = len_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if ((ch == 8'd0) || last)
                    begin
                        state_next = S_PRIME;
                    end
                end
            end

            S_PRIME:
            begin
                // One spare read so that a character written on the last
                // load edge is seen.
                fyear_next = '0;
                fmon_next  = '0;
                fday_next  = '0;
                fhour_next = '0;
                fmin_next  = '0;
                fsec_next  = '0;
                fzone_next = '0;
                got_next   = 1'b0;
                state_next = ovf_reg ? S_FAIL : S_DSP;
            end

            S_DSP:
            begin
                if (c == CH_SPACE)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if ((ldash_reg > ptr_reg) || (lslash_reg > ptr_reg))
                begin
                    p_next     = ptr_reg;
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_YDONE;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = S_TSP;
                end
            end

            S_YDONE:
            begin
                if ((ysat >= CENTURY_SPLIT) && (ysat < CENTURY_TOP))
                begin
                    fyear_next = ysat + ADD_1900;
                end
                else if ((ysat >= 16'sd0) && (ysat < CENTURY_SPLIT))
                begin
                    fyear_next = ysat + ADD_2000;
                end
                else
                begin
                    fyear_next = ysat;
                end
                state_next = S_YSKIP;
            end

            S_YSKIP, S_MOSKIP:
            begin
                if (is_dig(c))
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if ((c == CH_MINUS) || (c == CH_SLASH))
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    p_next     = ptr_reg + 1'b1;
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = (state_reg == S_YSKIP) ? S_MODONE : S_DDONE;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = S_FAIL;
                end
            end

            S_MODONE:
            begin
                fmon_next  = nlow;
                state_next = (nlow > MONTH_MAX) ? S_FAIL : S_MOSKIP;
            end

            S_DDONE:
            begin
                fday_next  = nlow;
                state_next = (nlow > DAY_MAX) ? S_FAIL : S_DSKIP;
            end

            S_DSKIP:
            begin
                if (is_dig(c))
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    got_next   = 1'b1;
                    state_next = S_TSP;
                end
            end

            S_TSP:
            begin
                if (c == CH_SPACE)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (lcolon_reg > ptr_reg)
                begin
                    p_next     = ptr_reg;
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_HDONE;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = got_reg ? S_ZSP : S_FAIL;
                end
            end

            S_HDONE:
            begin
                fhour_next = nlow;
                state_next = (nlow > HOUR_MAX) ? S_FAIL : S_HSKIP;
            end

            S_HSKIP, S_MISKIP:
            begin
                if (is_dig(c))
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (c == CH_COLON)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    p_next     = ptr_reg + 1'b1;
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = (state_reg == S_HSKIP) ? S_MIDONE : S_SDONE;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = S_FAIL;
                end
            end

            S_MIDONE:
            begin
                fmin_next  = nlow;
                state_next = (nlow > MINSEC_MAX) ? S_FAIL : S_MISKIP;
            end

            S_SDONE:
            begin
                fsec_next  = nlow;
                state_next = (nlow > MINSEC_MAX) ? S_FAIL : S_SSKIP;
            end

            S_SSKIP:
            begin
                if (is_dig(c) || (c == CH_DOT))
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    got_next   = 1'b1;
                    state_next = S_ZSP;
                end
            end

            S_ZSP:
            begin
                if (c == CH_SPACE)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if ((c == CH_MINUS) || (c == CH_PLUS))
                begin
                    minus_next = (c == CH_MINUS);
                    zp_next    = ptr_reg;
                    p_next     = ptr_reg;
                    if (remain <= LW'(3))
                    begin
                        end_next   = len_reg;
                        mag_next   = '0;
                        neg_next   = 1'b0;
                        ret_next   = S_ZSHORT;
                        state_next = S_RNWS;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + LW'(3);
                        state_next = S_ZC3;
                    end
                end
                else
                begin
                    state_next = S_OK;
                end
            end

            S_ZSHORT:
            begin
                fzone_next = ZONE_BASE + {nlow[5:0], 2'b00};
                state_next = S_OK;
            end

            S_ZC3:
            begin
                c3_next    = c;
                ptr_next   = zp_reg + LW'(4);
                state_next = S_ZC4;
            end

            S_ZC4:
            begin
                c4_next = c;
                if (c3_reg == CH_COLON)
                begin
                    ptr_next   = zp_reg + LW'(4);
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_ZAM;
                    state_next = S_RNWS;
                end
                else
                begin
                    ptr_next   = zp_reg;
                    state_next = S_ZBCHK;
                end
            end

            S_ZAM, S_ZBM, S_ZCM:
            begin
                // Quotient and remainder of the minutes by fifteen, truncated
                // toward zero as for a signed division.
                drem_next = zrem;
                q_next    = neg_reg ? (8'd0 - zqa) : zqa;
                unique case (state_reg)
                    S_ZAM:   state_next = S_ZAD;
                    S_ZBM:   state_next = S_ZBD;
                    default: state_next = S_ZCD;
                endcase
            end

            S_ZAD, S_ZBD, S_ZCD:
            begin
                if (drem_reg == 4'd0)
                begin
                    ptr_next   = zp_reg + 1'b1;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_ZHOUR;
                    state_next = S_RNWS;
                    unique case (state_reg)
                        S_ZAD:   end_next = len_reg;
                        S_ZBD:   end_next = zp_reg + LW'(3);
                        default: end_next = zp_reg + LW'(2);
                    endcase
                end
                else
                begin
                    unique case (state_reg)
                        S_ZAD:   state_next = S_ZBCHK;
                        S_ZBD:   state_next = S_ZCCHK;
                        default: state_next = S_OK;
                    endcase
                end
            end

            S_ZBCHK:
            begin
                if (is_dig(c3_reg) && is_dig(c4_reg))
                begin
                    ptr_next   = zp_reg + LW'(3);
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_ZBM;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = S_ZCCHK;
                end
            end

            S_ZCCHK:
            begin
                if (is_dig(c3_reg) && ((len_reg - zp_reg) == LW'(4)))
                begin
                    ptr_next   = zp_reg + LW'(2);
                    end_next   = len_reg;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    ret_next   = S_ZCM;
                    state_next = S_RNWS;
                end
                else
                begin
                    state_next = S_OK;
                end
            end

            S_ZHOUR:
            begin
                // Offset forms are mirrored about the zone base for a minus sign.
                if (minus_reg)
                begin
                    fzone_next = ZONE_MIRROR
                                 - (ZONE_BASE + {nlow[5:0], 2'b00} + q_reg);
                end
                else
                begin
                    fzone_next = ZONE_BASE + {nlow[5:0], 2'b00} + q_reg;
                end
                state_next = S_OK;
            end

            S_RNWS:
            begin
                if ((ptr_reg < end_reg) && is_ws(c))
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if ((ptr_reg < end_reg) && ((c == CH_PLUS) || (c == CH_MINUS)))
                begin
                    neg_next   = (c == CH_MINUS);
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_RNDIG;
                end
                else
                begin
                    state_next = S_RNDIG;
                end
            end

            S_RNDIG:
            begin
                if ((ptr_reg < end_reg) && is_dig(c))
                begin
                    mag_next = (acc > 35'h0_8000_0000) ? 32'h8000_0000 : acc[31:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    // Return to the caller with the parse position restored.
                    ptr_next   = p_reg;
                    state_next = ret_reg;
                end
            end

            S_OK, S_FAIL:
            begin
                done_next  = 1'b1;
                oval_next  = (state_reg == S_OK);
                oyear_next = (state_reg == S_OK) ? fyear_reg : 16'sd0;
                omon_next  = (state_reg == S_OK) ? fmon_reg  : 8'd0;
                oday_next  = (state_reg == S_OK) ? fday_reg  : 8'd0;
                ohour_next = (state_reg == S_OK) ? fhour_reg : 8'd0;
                omin_next  = (state_reg == S_OK) ? fmin_reg  : 8'd0;
                osec_next  = (state_reg == S_OK) ? fsec_reg  : 8'd0;
                ozone_next = (state_reg == S_OK) ? fzone_reg : 8'd0;
                len_next    = '0;
                ovf_next    = 1'b0;
                ldash_next  = '0;
                lslash_next = '0;
                lcolon_next = '0;
                ptr_next    = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            ldash_reg  <= '0;
            lslash_reg <= '0;
            lcolon_reg <= '0;
            ptr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            ldash_reg  <= ldash_next;
            lslash_reg <= lslash_next;
            lcolon_reg <= lcolon_next;
            ptr_reg    <= ptr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        end_reg   <= end_next;
        zp_reg    <= zp_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        minus_reg <= minus_next;
        got_reg   <= got_next;
        c3_reg    <= c3_next;
        c4_reg    <= c4_next;
        q_reg     <= q_next;
        drem_reg  <= drem_next;
        fyear_reg <= fyear_next;
        fmon_reg  <= fmon_next;
        fday_reg  <= fday_next;
        fhour_reg <= fhour_next;
        fmin_reg  <= fmin_next;
        fsec_reg  <= fsec_next;
        fzone_reg <= fzone_next;
        oval_reg  <= oval_next;
        oyear_reg <= oyear_next;
        omon_reg  <= omon_next;
        oday_reg  <= oday_next;
        ohour_reg <= ohour_next;
        omin_reg  <= omin_next;
        osec_reg  <= osec_next;
        ozone_reg <= ozone_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign valid_res = oval_reg;
    assign year      = oyear_reg;
    assign month     = omon_reg;
    assign day       = oday_reg;
    assign hour      = ohour_reg;
    assign minute    = omin_reg;
    assign second    = osec_reg;
    assign zone_code = ozone_reg;

endmodule

`default_nettype wire

[hdl/dtp_checker.sv]
`default_nettype none

module dtp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [7:0]  ch,
    input wire logic        last,
    input wire logic        done,
    input wire logic        valid_res,
    input wire logic [15:0] year,
    input wire logic [7:0]  month,
    input wire logic [7:0]  day,
    input wire logic [7:0]  hour,
    input wire logic [7:0]  minute,
    input wire logic [7:0]  second,
    input wire logic [7:0]  zone_code
);

    // A text end starts a parse.
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((ch == 8'd0) || last)) |=> busy)
        else $error("text end did not start a parse");

    // A plain character transfer keeps the block open for the next one.
    a_char_open: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (ch != 8'd0) && !last) |=> !busy)
        else $error("block busy after a plain character");

    // Each parse ends with exactly one result.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("parse ended without a result");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown for more than one cycle");

    // A failed parse reports every field as zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> ((year == 16'd0) && (month == 8'd0) &&
        (day == 8'd0) && (hour == 8'd0) && (minute == 8'd0) &&
        (second == 8'd0) && (zone_code == 8'd0)))
        else $error("failed result carries non-zero fields");

endmodule

bind date_time_text_parser_top dtp_checker u_dtp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ch        (ch),
    .last      (last),
    .done      (done),
    .valid_res (valid_res),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .zone_code (zone_code)
);

`default_nettype wire
